FILE: rtl/core/mdnm_pkg.sv
// Shared types and constants for the MD string and NM tag generator.
`default_nettype none
package mdnm_pkg;

	// base_kind codes
	localparam logic [1:0] KIND_PAIR = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_INS  = 2'd2;
	localparam logic [1:0] KIND_CLIP = 2'd3;

	// MD string characters
	localparam logic [7:0] CHAR_CARET = 8'h5e;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [3:0] DIGIT_HI   = 4'h3;

	localparam logic [15:0] NM_MAX = 16'hffff;

	// Work still to emit for one item, in emission order from the top field down
	typedef struct packed {
		logic pre_cnt;   // run count before the edit
		logic caret;     // '^' opening a deletion
		logic base;      // reference base of a mismatch or deletion
		logic end_cnt;   // final run count of the record
		logic end_zero;  // '0' closing a record right after an edit
	} emit_flags_t;

endpackage
`default_nettype wire

FILE: rtl/core/mdnm_front.sv
// Front end: accepts alignment items, keeps run and edit counts, builds emit descriptors.
`default_nettype none
module mdnm_front #(
	parameter int RUN_DIGITS = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire  [15:0]              s_axis_tdata,
	input  wire  [2:0]               s_axis_tuser,
	input  wire                      s_axis_tlast,
	input  wire                      queue_full,
	output logic                     push,
	output mdnm_pkg::emit_flags_t    push_flags,
	output logic [4*RUN_DIGITS-1:0]  push_bcd,
	output logic [7:0]               push_base,
	output logic [15:0]              push_nm
);

	localparam int BCD_W = 4 * RUN_DIGITS;

	logic [BCD_W-1:0] bcd_q;
	logic [15:0]      nm_q;

	logic [1:0]       kind;
	logic             first;
	logic [7:0]       read_base;
	logic [7:0]       ref_base;
	logic             rec_end;
	logic             accept;
	logic             mismatch;
	logic             match;
	logic             del;
	logic             nm_inc;
	logic [15:0]      nm_new;
	logic [BCD_W-1:0] bcd_new;

	// Saturating BCD increment: all nines holds
	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		logic             carry;
		logic             nines;
		r     = v;
		carry = 1'b1;
		nines = 1'b1;
		for (int i = 0; i < RUN_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd9) begin
				nines = 1'b0;
			end
			if (carry) begin
				if (v[4*i +: 4] >= 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = v[4*i +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return nines ? v : r;
	endfunction

	assign kind      = s_axis_tuser[1:0];
	assign first     = s_axis_tuser[2];
	assign read_base = s_axis_tdata[7:0];
	assign ref_base  = s_axis_tdata[15:8];
	assign rec_end   = s_axis_tlast;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign mismatch = (kind == mdnm_pkg::KIND_PAIR) && (read_base != ref_base);
	assign match    = (kind == mdnm_pkg::KIND_PAIR) && (read_base == ref_base);
	assign del      = (kind == mdnm_pkg::KIND_DEL);
	assign nm_inc   = mismatch || del || (kind == mdnm_pkg::KIND_INS);
	assign nm_new   = (nm_inc && (nm_q != mdnm_pkg::NM_MAX)) ? nm_q + 16'd1 : nm_q;

	always_comb begin
		push_flags.pre_cnt  = mismatch || (del && first);
		push_flags.caret    = del && first;
		push_flags.base     = mismatch || del;
		push_flags.end_cnt  = rec_end && !push_flags.pre_cnt;
		push_flags.end_zero = rec_end && push_flags.pre_cnt;
		if (push_flags.pre_cnt) begin
			bcd_new = '0;
		end else if (match) begin
			bcd_new = bcd_inc(bcd_q);
		end else begin
			bcd_new = bcd_q;
		end
	end

	// Only one count string per item needs digits: the prefix or the final count
	assign push_bcd  = push_flags.pre_cnt ? bcd_q : bcd_new;
	assign push_base = ref_base;
	assign push_nm   = nm_new;
	assign push      = accept && (push_flags != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
			nm_q  <= '0;
		end else if (accept) begin
			bcd_q <= rec_end ? '0 : bcd_new;
			nm_q  <= rec_end ? 16'd0 : nm_new;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/mdnm_queue.sv
// Small register queue of emit descriptors between front and back end.
`default_nettype none
module mdnm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("descriptor queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("descriptor queue underflow");

endmodule
`default_nettype wire

FILE: rtl/core/mdnm_back.sv
// Back end: serializes a descriptor into registered MD characters, one per cycle unless stalled.
`default_nettype none
module mdnm_back #(
	parameter int RUN_DIGITS = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      desc_valid,
	input  mdnm_pkg::emit_flags_t    desc_flags,
	input  wire  [4*RUN_DIGITS-1:0]  desc_bcd,
	input  wire  [7:0]               desc_base,
	input  wire  [15:0]              desc_nm,
	output logic                     desc_pop,
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	output logic [23:0]              m_axis_tdata,
	output logic [0:0]               m_axis_tuser,
	output logic                     m_axis_tlast
);

	localparam int BCD_W = 4 * RUN_DIGITS;
	localparam int IDX_W = $clog2(RUN_DIGITS);

	mdnm_pkg::emit_flags_t mask_q;
	mdnm_pkg::emit_flags_t mask_nx;
	logic [BCD_W-1:0]      bcd_q;
	logic [7:0]            base_q;
	logic [15:0]           nm_q;
	logic [IDX_W-1:0]      idx_q;

	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  end_q;
	logic [15:0]           nmo_q;

	logic                  busy;
	logic [3:0]            digit;
	logic [7:0]            char_nx;
	logic                  cnt_phase;
	logic                  cnt_done;
	logic                  last_char;
	logic                  rec_end;
	logic                  adv;
	logic                  fin;
	logic                  load;

	// Index of the highest non-zero digit; zero for a zero count
	function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] v);
		logic [IDX_W-1:0] t;
		t = '0;
		for (int i = 0; i < RUN_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd0) begin
				t = IDX_W'(i);
			end
		end
		return t;
	endfunction

	assign busy     = (mask_q != '0);
	assign digit    = bcd_q[{idx_q, 2'b00} +: 4];
	assign cnt_done = (idx_q == '0);
	assign rec_end  = mask_q.end_cnt || mask_q.end_zero;

	always_comb begin
		mask_nx   = mask_q;
		char_nx   = mdnm_pkg::CHAR_ZERO;
		cnt_phase = 1'b0;
		if (mask_q.pre_cnt) begin
			char_nx   = {mdnm_pkg::DIGIT_HI, digit};
			cnt_phase = 1'b1;
			if (cnt_done) begin
				mask_nx.pre_cnt = 1'b0;
			end
		end else if (mask_q.caret) begin
			char_nx       = mdnm_pkg::CHAR_CARET;
			mask_nx.caret = 1'b0;
		end else if (mask_q.base) begin
			char_nx      = base_q;
			mask_nx.base = 1'b0;
		end else if (mask_q.end_cnt) begin
			char_nx   = {mdnm_pkg::DIGIT_HI, digit};
			cnt_phase = 1'b1;
			if (cnt_done) begin
				mask_nx.end_cnt = 1'b0;
			end
		end else begin
			mask_nx.end_zero = 1'b0;
		end
	end

	assign last_char = busy && (mask_nx == '0);
	assign adv       = busy && (!out_valid_q || m_axis_tready);
	assign fin       = adv && last_char;
	assign load      = desc_valid && (!busy || fin);
	assign desc_pop  = load;

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q  <= desc_bcd;
			base_q <= desc_base;
			nm_q   <= desc_nm;
			idx_q  <= top_digit(desc_bcd);
		end else if (adv && cnt_phase && !cnt_done) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= desc_flags;
		end else if (adv) begin
			mask_q <= mask_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= char_nx;
			last_q <= last_char;
			end_q  <= last_char && rec_end;
			nmo_q  <= (last_char && rec_end) ? nm_q : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {nmo_q, char_q};
	assign m_axis_tuser  = last_q;
	assign m_axis_tlast  = end_q;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy)
		else $error("loaded descriptor carries no work");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> last_q)
		else $error("record end not on last character of its item");

	a_nm_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !end_q) |-> (nmo_q == 16'd0))
		else $error("edit count shown before record end");

endmodule
`default_nettype wire

FILE: rtl/core/md_nm_tag_generator.sv
// Top level of the MD string and NM edit distance generator.
// Takes one per-base alignment item per cycle and writes the SAM MD string one character per
// output item, with the NM edit distance on the record's last character. Matching aligned pairs
// only advance a saturating BCD run count; a mismatch writes the run count and the reference
// base, the first deleted base writes the run count and '^', every deleted base writes its
// reference base. Mismatches, deleted and inserted bases each add one to NM (saturating at
// 65535). The record's last item (tlast) writes the final run count, which is '0' when zero.
// Rate: the input takes one item every cycle as long as the descriptor queue has room; an item
// that produces k characters (up to RUN_DIGITS + 3) occupies the serializing back end until
// its last character is registered, and characters leave at one per cycle unless m_axis_tready
// stalls the output. Sustained throughput is therefore one item per cycle when averaged output
// is at most one character per item, else set by the back end; QUEUE_DEPTH descriptors absorb
// bursts. An accepted item passes the queue and the back end's descriptor and output registers.
`default_nettype none
module md_nm_tag_generator #(
	parameter int RUN_DIGITS  = 5,  // BCD digits of the match run counter, 3 to 8
	parameter int QUEUE_DEPTH = 4   // descriptor queue entries, a power of two
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] read_base, [15:8] ref_base
	input  wire  [2:0]  s_axis_tuser,   // [1:0] base_kind, [2] op_first
	input  wire         s_axis_tlast,   // record_end
	// MD characters
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] md_char, [23:8] nm_count
	output logic [0:0]  m_axis_tuser,   // [0] run_last
	output logic        m_axis_tlast    // md_end
);

	localparam int BCD_W   = 4 * RUN_DIGITS;
	localparam int FLAGS_W = $bits(mdnm_pkg::emit_flags_t);
	localparam int NM_LO   = FLAGS_W;
	localparam int BASE_LO = NM_LO + 16;
	localparam int BCD_LO  = BASE_LO + 8;
	localparam int DESC_W  = BCD_LO + BCD_W;

	logic                  push;
	mdnm_pkg::emit_flags_t push_flags;
	logic [BCD_W-1:0]      push_bcd;
	logic [7:0]            push_base;
	logic [15:0]           push_nm;
	logic                  queue_full;
	logic                  queue_nonempty;
	logic                  pop;
	logic [DESC_W-1:0]     wdata;
	logic [DESC_W-1:0]     rdata;
	mdnm_pkg::emit_flags_t pop_flags;

	// Front end: decode the item, update the counters, build a descriptor
	mdnm_front #(
		.RUN_DIGITS (RUN_DIGITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.queue_full    (queue_full),
		.push          (push),
		.push_flags    (push_flags),
		.push_bcd      (push_bcd),
		.push_base     (push_base),
		.push_nm       (push_nm)
	);

	// Pack descriptor: flags in the low bits, then NM, base, run count
	assign wdata = {push_bcd, push_base, push_nm, push_flags};

	mdnm_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wdata),
		.full     (queue_full),
		.pop      (pop),
		.rdata    (rdata),
		.nonempty (queue_nonempty)
	);

	assign pop_flags = mdnm_pkg::emit_flags_t'(rdata[FLAGS_W-1:0]);

	// Back end: walk the descriptor and drive the output register
	mdnm_back #(
		.RUN_DIGITS (RUN_DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.desc_valid    (queue_nonempty),
		.desc_flags    (pop_flags),
		.desc_bcd      (rdata[BCD_LO +: BCD_W]),
		.desc_base     (rdata[BASE_LO +: 8]),
		.desc_nm       (rdata[NM_LO +: 16]),
		.desc_pop      (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire
